@@ sv/lavm_pkg.sv @@
// Shared types, constants and the multiply-accumulate schedule of the look-at block.
`default_nettype none

package lavm_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int IN_W        = 32;
    localparam int DIFF_W      = IN_W + 1;
    localparam int RAW_W       = 64;            // unnormalized vector component
    localparam int MAG_W       = 64;
    localparam int VEC_W       = 34;            // unit and upward components
    localparam int ACC_W       = 2 * VEC_W + 2;
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int DIV_CNT_W   = $clog2(QUO_W);
    localparam int LEN_W       = 32;
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PC_W        = 5;
    localparam int SEL_W       = 5;

    localparam logic [MAG_W-1:0] NORM_HI = MAG_W'(1) << 30;
    localparam logic [MAG_W-1:0] NORM_LO = MAG_W'(1) << 29;

    typedef logic signed [IN_W-1:0]   word_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [RAW_W-1:0]  raw_t;
    typedef logic        [MAG_W-1:0]  mag_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        word_t [2:0] eye;
        diff_t [2:0] dir;
        word_t [2:0] up;
        logic        fzero;
    } item_t;

    typedef struct packed {
        logic [3:0] idx;
        word_t      value;
        logic       last;
        logic       degen;
    } result_t;

    // operand sources of the shared multiplier
    localparam logic [SEL_W-1:0] SRC_M0 = 5'd0,  SRC_M1 = 5'd1,  SRC_M2 = 5'd2;
    localparam logic [SEL_W-1:0] SRC_F0 = 5'd3,  SRC_F1 = 5'd4,  SRC_F2 = 5'd5;
    localparam logic [SEL_W-1:0] SRC_S0 = 5'd6,  SRC_S1 = 5'd7,  SRC_S2 = 5'd8;
    localparam logic [SEL_W-1:0] SRC_U0 = 5'd9,  SRC_U1 = 5'd10, SRC_U2 = 5'd11;
    localparam logic [SEL_W-1:0] SRC_H0 = 5'd12, SRC_H1 = 5'd13, SRC_H2 = 5'd14;
    localparam logic [SEL_W-1:0] SRC_E0 = 5'd15, SRC_E1 = 5'd16, SRC_E2 = 5'd17;

    // where a finished sum goes
    localparam logic [2:0] DST_NONE = 3'd0;
    localparam logic [2:0] DST_SUM  = 3'd1;
    localparam logic [2:0] DST_V    = 3'd2;
    localparam logic [2:0] DST_U    = 3'd3;
    localparam logic [2:0] DST_T    = 3'd4;

    localparam logic [1:0] LANE_X = 2'd0, LANE_Y = 2'd1, LANE_Z = 2'd2;

    localparam logic [PC_W-1:0] PC_SQ    = 5'd0;
    localparam logic [PC_W-1:0] PC_CROSS = 5'd3;
    localparam logic [PC_W-1:0] PC_UP    = 5'd9;

    typedef struct packed {
        logic [SEL_W-1:0] a_sel;
        logic [SEL_W-1:0] b_sel;
        logic             sub;
        logic             first;
        logic             last;
        logic [2:0]       dest;
        logic [1:0]       lane;
    } mac_op_t;

    function automatic mac_op_t mac_op(input logic [PC_W-1:0] pc);
        mac_op_t op;
        case (pc)
            // sum of squares
            5'd0:  op = '{SRC_M0, SRC_M0, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd1:  op = '{SRC_M1, SRC_M1, 1'b0, 1'b0, 1'b0, DST_NONE, LANE_X};
            5'd2:  op = '{SRC_M2, SRC_M2, 1'b0, 1'b0, 1'b1, DST_SUM,  LANE_X};
            // forward x up hint
            5'd3:  op = '{SRC_F1, SRC_H2, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd4:  op = '{SRC_F2, SRC_H1, 1'b1, 1'b0, 1'b1, DST_V,    LANE_X};
            5'd5:  op = '{SRC_F2, SRC_H0, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd6:  op = '{SRC_F0, SRC_H2, 1'b1, 1'b0, 1'b1, DST_V,    LANE_Y};
            5'd7:  op = '{SRC_F0, SRC_H1, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd8:  op = '{SRC_F1, SRC_H0, 1'b1, 1'b0, 1'b1, DST_V,    LANE_Z};
            // side x forward
            5'd9:  op = '{SRC_S1, SRC_F2, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd10: op = '{SRC_S2, SRC_F1, 1'b1, 1'b0, 1'b1, DST_U,    LANE_X};
            5'd11: op = '{SRC_S2, SRC_F0, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd12: op = '{SRC_S0, SRC_F2, 1'b1, 1'b0, 1'b1, DST_U,    LANE_Y};
            5'd13: op = '{SRC_S0, SRC_F1, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd14: op = '{SRC_S1, SRC_F0, 1'b1, 1'b0, 1'b1, DST_U,    LANE_Z};
            // translation dot products
            5'd15: op = '{SRC_S0, SRC_E0, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd16: op = '{SRC_S1, SRC_E1, 1'b0, 1'b0, 1'b0, DST_NONE, LANE_X};
            5'd17: op = '{SRC_S2, SRC_E2, 1'b0, 1'b0, 1'b1, DST_T,    LANE_X};
            5'd18: op = '{SRC_U0, SRC_E0, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd19: op = '{SRC_U1, SRC_E1, 1'b0, 1'b0, 1'b0, DST_NONE, LANE_X};
            5'd20: op = '{SRC_U2, SRC_E2, 1'b0, 1'b0, 1'b1, DST_T,    LANE_Y};
            5'd21: op = '{SRC_F0, SRC_E0, 1'b0, 1'b1, 1'b0, DST_NONE, LANE_X};
            5'd22: op = '{SRC_F1, SRC_E1, 1'b0, 1'b0, 1'b0, DST_NONE, LANE_X};
            5'd23: op = '{SRC_F2, SRC_E2, 1'b0, 1'b0, 1'b1, DST_T,    LANE_Z};
            default: op = '0;
        endcase
        return op;
    endfunction

    function automatic word_t sat_word(input acc_t x);
        word_t r;
        if (x[ACC_W-1:IN_W-1] == '0 || x[ACC_W-1:IN_W-1] == '1)
            r = x[IN_W-1:0];
        else if (x[ACC_W-1])
            r = {1'b1, {(IN_W-1){1'b0}}};
        else
            r = {1'b0, {(IN_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/lavm_front.sv @@
// Front end: takes items, forms the view direction, flags a zero one, queues them.
`default_nettype none

module lavm_front
    import lavm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire word_t eye_x,
    input  wire word_t eye_y,
    input  wire word_t eye_z,
    input  wire word_t target_x,
    input  wire word_t target_y,
    input  wire word_t target_z,
    input  wire word_t up_hint_x,
    input  wire word_t up_hint_y,
    input  wire word_t up_hint_z,
    output logic       item_valid,
    output item_t      item,
    input  wire logic  item_take
);

    item_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    item_t              new_item;
    logic               do_push, do_pop;

    always_comb
    begin
        new_item.eye[0] = eye_x;
        new_item.eye[1] = eye_y;
        new_item.eye[2] = eye_z;
        new_item.up[0]  = up_hint_x;
        new_item.up[1]  = up_hint_y;
        new_item.up[2]  = up_hint_z;
        new_item.dir[0] = DIFF_W'(target_x) - DIFF_W'(eye_x);
        new_item.dir[1] = DIFF_W'(target_y) - DIFF_W'(eye_y);
        new_item.dir[2] = DIFF_W'(target_z) - DIFF_W'(eye_z);
        new_item.fzero  = (target_x == eye_x) && (target_y == eye_y) && (target_z == eye_z);
    end

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= new_item;
    end

endmodule

`default_nettype wire

@@ sv/lavm_engine.sv @@
// Back end: sequencer with a shared multiplier, square root and divider; emits 16 entries.
`default_nettype none

module lavm_engine
    import lavm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire item_t   item,
    output logic         item_take,
    input  wire logic    out_full,
    output logic         out_push,
    output result_t      out_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ABS      = 4'd1;
    localparam logic [3:0] S_NORM     = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_ACC      = 4'd4;
    localparam logic [3:0] S_WB       = 4'd5;
    localparam logic [3:0] S_SQRT     = 4'd6;
    localparam logic [3:0] S_DIV_INIT = 4'd7;
    localparam logic [3:0] S_DIV_STEP = 4'd8;
    localparam logic [3:0] S_DIV_END  = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_FWD  = 2'd2;
    localparam logic [1:0] COL_T    = 2'd3;
    localparam logic [3:0] ENT_LAST = 4'd15;

    localparam logic [1:0] PASS_FWD  = 2'd0;

    localparam acc_t HALF = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t ONE  = acc_t'(1) <<< FRAC_BITS;

    // control
    logic [3:0]            state_reg, state_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [SQRT_CNT_W-1:0] scnt_reg, scnt_next;
    logic [DIV_CNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [1:0]            k_reg, k_next;
    logic [1:0]            pass_reg, pass_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic                  degen_reg, degen_next;

    // datapath
    word_t             eye_reg [3], eye_next [3];
    word_t             up_reg [3], up_next [3];
    raw_t              v_reg [3], v_next [3];
    mag_t              m_reg [3], m_next [3];
    vec_t              f_reg [3], f_next [3];
    vec_t              s_reg [3], s_next [3];
    vec_t              u_reg [3], u_next [3];
    acc_t              t_reg [3], t_next [3];
    acc_t              prod_reg, prod_next;
    acc_t              acc_reg, acc_next;
    mag_t              n_reg, n_next;
    mag_t              r_reg, r_next;
    mag_t              bit_reg, bit_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  nlow_reg, nlow_next;
    logic [QUO_W-1:0]  q_reg, q_next;

    mac_op_t           op;
    mag_t              mx;
    vec_t              a_op, b_op;
    acc_t              acc_base, rounded, raw_val;
    logic              raw_neg;
    mag_t              trial_sq, dividend;
    logic [LEN_W:0]    trial_div;
    logic [LEN_W-1:0]  len;
    vec_t              quo_signed;
    logic [1:0]        col, row;

    function automatic vec_t pick(input logic [SEL_W-1:0] sel);
        vec_t r;
        case (sel)
            SRC_M0:  r = vec_t'(m_reg[0]);
            SRC_M1:  r = vec_t'(m_reg[1]);
            SRC_M2:  r = vec_t'(m_reg[2]);
            SRC_F0:  r = f_reg[0];
            SRC_F1:  r = f_reg[1];
            SRC_F2:  r = f_reg[2];
            SRC_S0:  r = s_reg[0];
            SRC_S1:  r = s_reg[1];
            SRC_S2:  r = s_reg[2];
            SRC_U0:  r = u_reg[0];
            SRC_U1:  r = u_reg[1];
            SRC_U2:  r = u_reg[2];
            SRC_H0:  r = vec_t'(up_reg[0]);
            SRC_H1:  r = vec_t'(up_reg[1]);
            SRC_H2:  r = vec_t'(up_reg[2]);
            SRC_E0:  r = vec_t'(eye_reg[0]);
            SRC_E1:  r = vec_t'(eye_reg[1]);
            SRC_E2:  r = vec_t'(eye_reg[2]);
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        op   = mac_op(pc_reg);
        a_op = pick(op.a_sel);
        b_op = pick(op.b_sel);

        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];

        acc_base = op.first ? '0 : acc_reg;
        rounded  = (acc_reg + HALF) >>> FRAC_BITS;
        trial_sq = r_reg + bit_reg;
        len      = r_reg[LEN_W-1:0];
        dividend = (m_reg[k_reg] << FRAC_BITS) + (r_reg >> 1);
        trial_div = {rem_reg, nlow_reg[QUO_W-1]};
        quo_signed = v_reg[k_reg][RAW_W-1] ? -vec_t'(q_reg) : vec_t'(q_reg);

        // column-major entry: col picks the vector lane, row the basis vector
        col = cnt_reg[3:2];
        row = cnt_reg[1:0];
        raw_val = '0;
        raw_neg = 1'b0;
        if (col == COL_T)
        begin
            case (row)
                ROW_SIDE: begin raw_val = t_reg[0]; raw_neg = 1'b1; end
                ROW_UP:   begin raw_val = t_reg[1]; raw_neg = 1'b1; end
                ROW_FWD:  raw_val = t_reg[2];
                default:  raw_val = ONE;
            endcase
        end
        else
        begin
            case (row)
                ROW_SIDE: raw_val = acc_t'(s_reg[col]);
                ROW_UP:   raw_val = acc_t'(u_reg[col]);
                ROW_FWD:  begin raw_val = acc_t'(f_reg[col]); raw_neg = 1'b1; end
                default:  raw_val = '0;
            endcase
        end
        if (degen_reg && cnt_reg != ENT_LAST)
            raw_val = '0;

        out_data.idx   = cnt_reg;
        out_data.value = sat_word(raw_neg ? -raw_val : raw_val);
        out_data.last  = (cnt_reg == ENT_LAST);
        out_data.degen = degen_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        scnt_next  = scnt_reg;
        dcnt_next  = dcnt_reg;
        k_next     = k_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        degen_next = degen_reg;
        eye_next   = eye_reg;
        up_next    = up_reg;
        v_next     = v_reg;
        m_next     = m_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        u_next     = u_reg;
        t_next     = t_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        nlow_next  = nlow_reg;
        q_next     = q_reg;
        item_take  = 1'b0;
        out_push   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_take = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        eye_next[i] = item.eye[i];
                        up_next[i]  = item.up[i];
                        v_next[i]   = RAW_W'($signed(item.dir[i]));
                    end
                    pass_next  = PASS_FWD;
                    degen_next = item.fzero;
                    cnt_next   = '0;
                    state_next = item.fzero ? S_EMIT : S_ABS;
                end
            end

            S_ABS:
            begin
                for (int i = 0; i < 3; i++)
                    m_next[i] = v_reg[i][RAW_W-1] ? mag_t'(-v_reg[i]) : mag_t'(v_reg[i]);
                if (v_reg[0] == '0 && v_reg[1] == '0 && v_reg[2] == '0)
                begin
                    degen_next = 1'b1;
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_NORM;
            end

            // one bit of common shift per cycle until the largest is in [2^29, 2^30)
            S_NORM:
            begin
                if (mx >= NORM_HI)
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] >> 1;
                end
                else if (mx < NORM_LO)
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] << 1;
                end
                else
                begin
                    pc_next    = PC_SQ;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                prod_next  = acc_t'(a_op * b_op);
                state_next = S_ACC;
            end

            S_ACC:
            begin
                acc_next = op.sub ? acc_base - prod_reg : acc_base + prod_reg;
                if (op.last)
                    state_next = S_WB;
                else
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_MUL;
                end
            end

            S_WB:
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = S_MUL;
                case (op.dest)
                    DST_SUM:
                    begin
                        n_next     = acc_reg[MAG_W-1:0];
                        r_next     = '0;
                        bit_next   = mag_t'(1) << (2 * (SQRT_STEPS - 1));
                        scnt_next  = '0;
                        state_next = S_SQRT;
                    end
                    DST_V:
                    begin
                        v_next[op.lane] = acc_reg[RAW_W-1:0];
                        if (op.lane == LANE_Z)
                        begin
                            pass_next  = ~PASS_FWD;
                            state_next = S_ABS;
                        end
                    end
                    DST_U:
                        u_next[op.lane] = rounded[VEC_W-1:0];
                    DST_T:
                    begin
                        t_next[op.lane] = rounded;
                        if (op.lane == LANE_Z)
                        begin
                            cnt_next   = '0;
                            state_next = S_EMIT;
                        end
                    end
                    default:
                        state_next = S_MUL;
                endcase
            end

            // digit-pair integer square root, one step per cycle
            S_SQRT:
            begin
                if (n_reg >= trial_sq)
                begin
                    n_next = n_reg - trial_sq;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                    r_next = r_reg >> 1;
                bit_next  = bit_reg >> 2;
                scnt_next = scnt_reg + 1'b1;
                if (scnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
                begin
                    k_next     = '0;
                    state_next = S_DIV_INIT;
                end
            end

            // quotient is known to fit QUO_W bits, so the top of the dividend starts below len
            S_DIV_INIT:
            begin
                rem_next   = LEN_W'(dividend >> QUO_W);
                nlow_next  = dividend[QUO_W-1:0];
                q_next     = '0;
                dcnt_next  = '0;
                state_next = S_DIV_STEP;
            end

            S_DIV_STEP:
            begin
                if (trial_div >= {1'b0, len})
                begin
                    rem_next = LEN_W'(trial_div - {1'b0, len});
                    q_next   = {q_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial_div[LEN_W-1:0];
                    q_next   = {q_reg[QUO_W-2:0], 1'b0};
                end
                nlow_next = nlow_reg << 1;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_CNT_W'(QUO_W - 1))
                    state_next = S_DIV_END;
            end

            S_DIV_END:
            begin
                if (pass_reg == PASS_FWD)
                    f_next[k_reg] = quo_signed;
                else
                    s_next[k_reg] = quo_signed;
                k_next = k_reg + 1'b1;
                if (k_reg == LANE_Z)
                begin
                    pc_next    = (pass_reg == PASS_FWD) ? PC_CROSS : PC_UP;
                    state_next = S_MUL;
                end
                else
                    state_next = S_DIV_INIT;
            end

            S_EMIT:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == ENT_LAST)
                        state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            scnt_reg  <= '0;
            dcnt_reg  <= '0;
            k_reg     <= '0;
            pass_reg  <= PASS_FWD;
            cnt_reg   <= '0;
            degen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            scnt_reg  <= scnt_next;
            dcnt_reg  <= dcnt_next;
            k_reg     <= k_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
            degen_reg <= degen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eye_reg  <= eye_next;
        up_reg   <= up_next;
        v_reg    <= v_next;
        m_reg    <= m_next;
        f_reg    <= f_next;
        s_reg    <= s_next;
        u_reg    <= u_next;
        t_reg    <= t_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        n_reg    <= n_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        nlow_reg <= nlow_next;
        q_reg    <= q_next;
    end

endmodule

`default_nettype wire

@@ sv/lavm_out_queue.sv @@
// Result queue between the engine and the output ports.
`default_nettype none

module lavm_out_queue
    import lavm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    output logic         full,
    output logic         empty,
    input  wire logic    pop,
    output result_t      rd_data
);

    result_t            q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = q_reg[rd_ptr_reg];
    assign do_push = wr_en && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

@@ sv/look_at_view_matrix_core.sv @@
// Top level of the look-at view matrix generator.
//
// Each transfer on the input queue carries eye, target and up hint points in signed
// Q16.16; the block answers with sixteen transfers on the result queue, the entries
// of the column-major view matrix in index order 0..15, last_entry marking entry 15.
// A target equal to the eye, or an up hint parallel to the view direction, sets
// degenerate on all sixteen entries and zeroes every computed entry (entry 15 stays
// 1.0). Values saturate to 32 bits. Two 32-step square roots and six restoring
// divisions dominate the work on an item; the normalizing shifter shifts one bit
// at a time, and the single shared 34x34 multiplier registers each product.
// A degenerate item ends sooner: the sixteen entries start as soon as the zero
// vector is found (right after the take when the target equals the eye).
// A two-entry queue at each side lets the next item be taken while results are
// still draining.
`default_nettype none

module look_at_view_matrix_core
    import lavm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    // input queue
    input  wire logic  push,
    output logic       full,
    input  wire word_t eye_x,
    input  wire word_t eye_y,
    input  wire word_t eye_z,
    input  wire word_t target_x,
    input  wire word_t target_y,
    input  wire word_t target_z,
    input  wire word_t up_hint_x,
    input  wire word_t up_hint_y,
    input  wire word_t up_hint_z,
    // result queue
    output logic       empty,
    input  wire logic  pop,
    output logic [3:0] entry_index,
    output word_t      matrix_value,
    output logic       last_entry,
    output logic       degenerate
);

    item_t   item;
    logic    item_valid, item_take;
    logic    res_push, res_full;
    result_t res_data, res_head;

    // front: forms target - eye and a zero-direction flag, queues the item
    lavm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .eye_x      (eye_x),
        .eye_y      (eye_y),
        .eye_z      (eye_z),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_z   (target_z),
        .up_hint_x  (up_hint_x),
        .up_hint_y  (up_hint_y),
        .up_hint_z  (up_hint_z),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // back: normalize, cross products, dot products, then emit the matrix
    lavm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_data   (res_data)
    );

    lavm_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (res_head)
    );

    assign entry_index  = res_head.idx;
    assign matrix_value = res_head.value;
    assign last_entry   = res_head.last;
    assign degenerate   = res_head.degen;

endmodule

`default_nettype wire

@@ sv/lavm_checker.sv @@
// Port-level checks on the result stream of the look-at block, bound to the top level.
`default_nettype none

module lavm_checker
    import lavm_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [3:0] entry_index,
    input wire word_t      matrix_value,
    input wire logic       last_entry,
    input wire logic       degenerate
);

    a_last_marks_final: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_entry == (entry_index == 4'd15)))
        else $error("last_entry does not match entry 15");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_entry) ##1 !empty |-> entry_index == $past(entry_index) + 4'd1)
        else $error("entry index did not advance by one");

    a_run_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last_entry) ##1 !empty |-> entry_index == 4'd0)
        else $error("new run does not start at entry 0");

    a_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_entry) ##1 !empty |-> degenerate == $past(degenerate))
        else $error("degenerate changed within a run");

    a_corner_one: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_entry) |-> matrix_value == (word_t'(1) <<< FRAC_BITS))
        else $error("entry 15 is not 1.0");

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .entry_index  (entry_index),
    .matrix_value (matrix_value),
    .last_entry   (last_entry),
    .degenerate   (degenerate)
);

`default_nettype wire

@@ tb/tb_look_at_view_matrix_core.sv @@
// Self-checking testbench for the look-at view matrix core.
`default_nettype none

module tb_look_at_view_matrix_core;
    import lavm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One camera setup: eye, target and up hint, nine signed Q16.16 words.
    typedef struct {
        word_t eye [3];
        word_t tgt [3];
        word_t uph [3];
    } camera_t;

    // One matrix entry as it should leave the result queue.
    typedef struct {
        logic [3:0] idx;
        word_t      value;
        logic       last;
        logic       degen;
    } entry_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    word_t      eye_x, eye_y, eye_z;
    word_t      target_x, target_y, target_z;
    word_t      up_hint_x, up_hint_y, up_hint_z;
    logic       empty;
    logic       pop;
    logic [3:0] entry_index;
    word_t      matrix_value;
    logic       last_entry;
    logic       degenerate;

    look_at_view_matrix_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .eye_x        (eye_x),
        .eye_y        (eye_y),
        .eye_z        (eye_z),
        .target_x     (target_x),
        .target_y     (target_y),
        .target_z     (target_z),
        .up_hint_x    (up_hint_x),
        .up_hint_y    (up_hint_y),
        .up_hint_z    (up_hint_z),
        .empty        (empty),
        .pop          (pop),
        .entry_index  (entry_index),
        .matrix_value (matrix_value),
        .last_entry   (last_entry),
        .degenerate   (degenerate)
    );

    camera_t cameras_to_send [$];   // filled by the stimulus block, drained by the driver
    entry_t  matrix_expected [$];   // predicted entries, oldest first
    camera_t cam_on_bus;            // setup currently offered on the input ports
    int      mismatches;
    int      entries_seen;

    // ------------------------------------------------------------------
    // Predictor: fixed-point look-at math, done in 64-bit integers.
    // ------------------------------------------------------------------

    // floor(sqrt(n)), digit-by-digit
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Normalize to unit length in Q16.16; returns 0 for a zero vector.
    // Magnitudes are first brought into [2^29, 2^30) by a common shift.
    function automatic bit unit_vec(input longint v [3], output longint u [3]);
        logic [63:0] m [3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
            if (m[i] > mx)
                mx = m[i];
            u[i] = 0;
        end
        if (mx == 0)
            return 0;
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
            sum = sum + m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    // divide by 2^FRAC_BITS, ties toward +infinity (arithmetic shift floors)
    function automatic longint round_frac(input longint v);
        return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic word_t clamp_word(input longint v);
        if (v > longint'(32'sh7fffffff))
            return 32'sh7fffffff;
        if (v < -longint'(64'h80000000))
            return 32'sh80000000;
        return word_t'(v);
    endfunction

    // Append the sixteen entries of the view matrix for one camera setup.
    task automatic predict_view_matrix(input camera_t c);
        longint eye [3], tgt [3], uph [3];
        longint dir [3], fwd [3], side_raw [3], side [3], upw [3];
        longint mat [16];
        bit     ok;
        entry_t e;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'(c.eye[i]);
            tgt[i] = longint'(c.tgt[i]);
            uph[i] = longint'(c.uph[i]);
            dir[i] = tgt[i] - eye[i];
        end
        for (int i = 0; i < 16; i++)
            mat[i] = 0;
        ok = unit_vec(dir, fwd);
        if (ok)
        begin
            side_raw[0] = fwd[1] * uph[2] - fwd[2] * uph[1];
            side_raw[1] = fwd[2] * uph[0] - fwd[0] * uph[2];
            side_raw[2] = fwd[0] * uph[1] - fwd[1] * uph[0];
            ok = unit_vec(side_raw, side);
        end
        if (ok)
        begin
            upw[0] = round_frac(side[1] * fwd[2] - side[2] * fwd[1]);
            upw[1] = round_frac(side[2] * fwd[0] - side[0] * fwd[2]);
            upw[2] = round_frac(side[0] * fwd[1] - side[1] * fwd[0]);
            for (int i = 0; i < 3; i++)
            begin
                mat[4 * i]     = side[i];
                mat[4 * i + 1] = upw[i];
                mat[4 * i + 2] = -fwd[i];
            end
            mat[12] = -round_frac(side[0] * eye[0] + side[1] * eye[1] + side[2] * eye[2]);
            mat[13] = -round_frac(upw[0] * eye[0] + upw[1] * eye[1] + upw[2] * eye[2]);
            mat[14] = round_frac(fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2]);
        end
        mat[15] = longint'(1) << FRAC_BITS;
        for (int i = 0; i < 16; i++)
        begin
            e.idx   = 4'(i);
            e.value = clamp_word(mat[i]);
            e.last  = (i == 15);
            e.degen = !ok;
            matrix_expected.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic camera_t make_camera(input word_t ex, ey, ez, tx, ty, tz,
                                            input word_t ux, uy, uz);
        camera_t c;
        c.eye[0] = ex; c.eye[1] = ey; c.eye[2] = ez;
        c.tgt[0] = tx; c.tgt[1] = ty; c.tgt[2] = tz;
        c.uph[0] = ux; c.uph[1] = uy; c.uph[2] = uz;
        return c;
    endfunction

    // Mix of full-range, scene-sized and extreme values.
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3, 4: return word_t'($urandom);
            5:       return word_t'($urandom_range(0, 32'h1ff) - 32'h100);
            default: return word_t'($urandom_range(0, 32'h7fffff) - 32'h400000);
        endcase
    endfunction

    function automatic camera_t random_camera();
        camera_t c;
        int      kind;
        kind = $urandom_range(0, 19);
        for (int i = 0; i < 3; i++)
        begin
            c.eye[i] = pick_word();
            c.tgt[i] = pick_word();
            c.uph[i] = pick_word();
        end
        if (kind == 0)
            c.tgt = c.eye;                      // target on the eye
        else if (kind == 1)
        begin
            for (int i = 0; i < 3; i++)         // up hint along the view direction
            begin
                c.eye[i] = word_t'($urandom_range(0, 32'hfffff) - 32'h80000);
                c.tgt[i] = word_t'($urandom_range(0, 32'hfffff) - 32'h80000);
                c.uph[i] = c.tgt[i] - c.eye[i];
            end
        end
        else if (kind == 2)
            for (int i = 0; i < 3; i++)
                c.uph[i] = '0;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Slowest run: 173 items, with every result stalled and long sender
    // gaps, is well under this.
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of transfers separated by random gaps.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            eye_x      <= '0;  eye_y    <= '0;  eye_z    <= '0;
            target_x   <= '0;  target_y <= '0;  target_z <= '0;
            up_hint_x  <= '0;  up_hint_y <= '0; up_hint_z <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // transfer completes this edge: predict from what was on the ports
            if (push && !full)
                predict_view_matrix(cam_on_bus);
            if (!(push && full))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (cameras_to_send.size() > 0)
                begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 6);
                    cam_on_bus = cameras_to_send.pop_front();
                    eye_x     <= cam_on_bus.eye[0];
                    eye_y     <= cam_on_bus.eye[1];
                    eye_z     <= cam_on_bus.eye[2];
                    target_x  <= cam_on_bus.tgt[0];
                    target_y  <= cam_on_bus.tgt[1];
                    target_z  <= cam_on_bus.tgt[2];
                    up_hint_x <= cam_on_bus.uph[0];
                    up_hint_y <= cam_on_bus.uph[1];
                    up_hint_z <= cam_on_bus.uph[2];
                    push      <= 1'b1;
                    burst_left--;
                    // sometimes no gap at all, sometimes a long one
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer and shapes pop.
    // ------------------------------------------------------------------
    int     pop_mode;
    int     mode_left;
    int     hold_left;
    bit     long_hold_done;
    entry_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop            <= 1'b0;
            pop_mode       = 0;
            mode_left      = 0;
            hold_left      = 0;
            long_hold_done = 0;
            entries_seen   = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                entries_seen++;
                if (matrix_expected.size() == 0)
                begin
                    $display("%0t: unexpected entry, expected none, actual idx=%0d value=%h",
                             $realtime, entry_index, matrix_value);
                    mismatches++;
                end
                else
                begin
                    want = matrix_expected.pop_front();
                    if (entry_index !== want.idx)
                    begin
                        $display("%0t: entry_index expected %0d actual %0d",
                                 $realtime, want.idx, entry_index);
                        mismatches++;
                    end
                    if (matrix_value !== want.value)
                    begin
                        $display("%0t: matrix_value[%0d] expected %h actual %h",
                                 $realtime, want.idx, want.value, matrix_value);
                        mismatches++;
                    end
                    if (last_entry !== want.last)
                    begin
                        $display("%0t: last_entry[%0d] expected %b actual %b",
                                 $realtime, want.idx, want.last, last_entry);
                        mismatches++;
                    end
                    if (degenerate !== want.degen)
                    begin
                        $display("%0t: degenerate[%0d] expected %b actual %b",
                                 $realtime, want.idx, want.degen, degenerate);
                        mismatches++;
                    end
                end
            end

            // one long back-pressure stretch, once traffic is flowing
            if (!long_hold_done && entries_seen >= 600)
            begin
                long_hold_done = 1;
                hold_left      = 3000;
            end

            if (mode_left == 0)
            begin
                pop_mode  = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;

            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                case (pop_mode)
                    0:       pop <= 1'b1;                           // free flowing
                    1:       pop <= ($urandom_range(0, 1) == 0);
                    default: pop <= ($urandom_range(0, 3) == 0);    // mostly stalled
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin
        mismatches = 0;
        // directed: plain view, each degenerate case, extremes of every field
        cameras_to_send.push_back(make_camera(0, 0, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0));
        cameras_to_send.push_back(make_camera(32'sh10000, 32'sh20000, 32'sh30000,
                                              32'sh10000, 32'sh20000, 32'sh30000,
                                              0, 32'sh10000, 0));
        cameras_to_send.push_back(make_camera(0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0));
        cameras_to_send.push_back(make_camera(0, 0, 0, 32'sh10000, 32'sh20000, 0,
                                              32'sh30000, 32'sh60000, 0));
        cameras_to_send.push_back(make_camera(0, 0, 0, 1, 0, 0, 0, 1, 0));
        cameras_to_send.push_back(make_camera(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                              32'sh80000000, 32'sh80000000, 32'sh80000000,
                                              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
        cameras_to_send.push_back(make_camera(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                              32'sh80000000, 32'sh7fffffff, 32'sh80000000));
        cameras_to_send.push_back(make_camera(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                              32'sh7ffffffe, 32'sh7fffffff, 32'sh7fffffff,
                                              0, 32'sh7fffffff, 0));
        cameras_to_send.push_back(make_camera(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                              32'sh80000000, 32'sh7fffffff, 32'sh80000001,
                                              32'sh80000000, 0, 0));
        cameras_to_send.push_back(make_camera(-1, -1, -1, 1, 1, 1, -1, 1, -1));
        cameras_to_send.push_back(make_camera(32'shffff, 32'sh5555, 32'shaaaa,
                                              32'sh7fff0000, 32'sh12345678, 32'sh80000000,
                                              32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f));
        cameras_to_send.push_back(make_camera(32'sh01000000, 32'shff000000, 32'sh00100000,
                                              0, 0, 0, 0, 0, 32'sh7fffffff));
        cameras_to_send.push_back(make_camera(32'sh80000000, 0, 0,
                                              32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0));

        // let the block drain completely before the random part
        wait (cameras_to_send.size() == 0 && !push && matrix_expected.size() == 0);

        for (int n = 0; n < 160; n++)
        begin
            cameras_to_send.push_back(random_camera());
            if (n == 80)
            begin
                // sender pause until every outstanding entry has arrived
                wait (cameras_to_send.size() == 0 && !push && matrix_expected.size() == 0);
            end
        end

        wait (cameras_to_send.size() == 0 && !push && matrix_expected.size() == 0);
        repeat (400) @(posedge clk);

        if (mismatches == 0 && matrix_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ look_at_view_matrix_core.f @@
sv/lavm_pkg.sv
sv/lavm_front.sv
sv/lavm_engine.sv
sv/lavm_out_queue.sv
sv/look_at_view_matrix_core.sv
sv/lavm_checker.sv
tb/tb_look_at_view_matrix_core.sv
